// File: rtl/owbm_pkg.sv
// Package for the 1-Wire bus master: command codes, sequence phases,
// timing register indexes and stream word widths.
// No dependencies.
package owbm_pkg;

  localparam int TIME_WIDTH_DEFAULT = 10;
  localparam int CFG_WIDTH          = 10;
  localparam int CFG_COUNT          = 7;
  localparam int PADDR_WIDTH        = 5;
  localparam int APB_DATA_WIDTH     = 32;
  localparam int IN_TDATA_WIDTH     = 16;
  localparam int OUT_TDATA_WIDTH    = 16;
  localparam int MODE_WIDTH         = 2;

  localparam logic [CFG_WIDTH-1:0] RESET_LOW_INIT    = 10'd500;
  localparam logic [CFG_WIDTH-1:0] PRES_WAIT_INIT    = 10'd38;
  localparam logic [CFG_WIDTH-1:0] PRES_TAIL_INIT    = 10'd142;
  localparam logic [CFG_WIDTH-1:0] SLOT_START_INIT   = 10'd1;
  localparam logic [CFG_WIDTH-1:0] SLOT_HOLD_INIT    = 10'd77;
  localparam logic [CFG_WIDTH-1:0] SLOT_REC_INIT     = 10'd1;
  localparam logic [CFG_WIDTH-1:0] SAMPLE_DELAY_INIT = 10'd1;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_PRE   = 4'd1,
    PH_RST_LOW   = 4'd2,
    PH_RST_WAIT  = 4'd3,
    PH_RST_TAIL  = 4'd4,
    PH_RST_POST  = 4'd5,
    PH_WR_START  = 4'd6,
    PH_WR_BIT    = 4'd7,
    PH_WR_REC    = 4'd8,
    PH_RD_START  = 4'd9,
    PH_RD_DELAY  = 4'd10,
    PH_RD_HOLD   = 4'd11,
    PH_RD_REC    = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW    = 3'd0,
    REG_PRES_WAIT    = 3'd1,
    REG_PRES_TAIL    = 3'd2,
    REG_SLOT_START   = 3'd3,
    REG_SLOT_HOLD    = 3'd4,
    REG_SLOT_REC     = 3'd5,
    REG_SAMPLE_DELAY = 3'd6
  } reg_idx_t;

endpackage

// File: rtl/one_wire_bus_master.sv
// 1-Wire bus master, standard speed, stepped by one-microsecond tick words.
// Timing registers on an APB port; uses owbm_pkg.
//
//   channel   dir   handshake              contents
//   s_axis    in    tvalid/tready          tuser: mode; tdata: bus_level, data_byte
//   m_axis    out   tvalid/tready          tdata: drive, busy, done, presence, byte, rejected
//   apb       in    psel/penable/pready    seven 10-bit timing registers at 4*i
//
// One word in, one word out; a word is taken every cycle while the output
// register is empty or being drained, so the rate is one word per cycle.
// The sequencer state updates at the edge that takes the word.
// Reset (rst, synchronous) idles the sequencer, loads the default timings
// and empties the output register.
// A stalled output holds its word and stalls the input only while full.
module one_wire_bus_master #(
  parameter int TIME_WIDTH = owbm_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [0] bus_level, [8:1] data_byte, [15:9] zero
  input  logic [owbm_pkg::IN_TDATA_WIDTH-1:0]       s_axis_tdata,
  // [1:0] mode
  input  logic [owbm_pkg::MODE_WIDTH-1:0]           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // [0] bus_drive_low, [1] busy_res, [2] done_res, [3] presence_level,
  // [11:4] read_byte, [12] cmd_rejected, [15:13] zero
  output logic [owbm_pkg::OUT_TDATA_WIDTH-1:0]      m_axis_tdata,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [owbm_pkg::PADDR_WIDTH-1:0]          paddr,
  input  logic [owbm_pkg::APB_DATA_WIDTH-1:0]       pwdata,
  output logic [owbm_pkg::APB_DATA_WIDTH-1:0]       prdata,
  output logic                                      pready
);

  localparam int CW = owbm_pkg::CFG_WIDTH;
  localparam int EW = (TIME_WIDTH > CW) ? TIME_WIDTH : CW;
  localparam logic [EW-1:0] TIME_MAX = EW'({TIME_WIDTH{1'b1}});
  localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

  logic [CW-1:0] reset_low_time, presence_wait, presence_tail, slot_start;
  logic [CW-1:0] slot_hold, slot_recovery, read_sample_delay;

  owbm_pkg::phase_t          phase, phase_next, phase_adv, enter_phase;
  logic [TIME_WIDTH-1:0]     time_left, time_left_next, time_dec, enter_time;
  logic [2:0]                bit_index, bit_index_next;
  logic [7:0]                shift_byte, shift_byte_next;
  logic                      presence_seen, presence_seen_next;
  logic [7:0]                read_result, read_result_next;
  logic                      enter_en, done, rejected, drive;
  owbm_pkg::reg_idx_t        enter_reg;
  logic [CW-1:0]             cfg_sel;
  logic [EW-1:0]             cfg_ext;

  owbm_pkg::mode_t           mode;
  logic                      bus_level;
  logic [7:0]                data_byte;
  logic                      s_accept, cfg_write;

  assign mode      = owbm_pkg::mode_t'(s_axis_tuser);
  assign bus_level = s_axis_tdata[0];
  assign data_byte = s_axis_tdata[8:1];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time    <= owbm_pkg::RESET_LOW_INIT;
      presence_wait     <= owbm_pkg::PRES_WAIT_INIT;
      presence_tail     <= owbm_pkg::PRES_TAIL_INIT;
      slot_start        <= owbm_pkg::SLOT_START_INIT;
      slot_hold         <= owbm_pkg::SLOT_HOLD_INIT;
      slot_recovery     <= owbm_pkg::SLOT_REC_INIT;
      read_sample_delay <= owbm_pkg::SAMPLE_DELAY_INIT;
    end else if (cfg_write) begin
      case (owbm_pkg::reg_idx_t'(paddr[4:2]))
        owbm_pkg::REG_RESET_LOW:    reset_low_time    <= pwdata[CW-1:0];
        owbm_pkg::REG_PRES_WAIT:    presence_wait     <= pwdata[CW-1:0];
        owbm_pkg::REG_PRES_TAIL:    presence_tail     <= pwdata[CW-1:0];
        owbm_pkg::REG_SLOT_START:   slot_start        <= pwdata[CW-1:0];
        owbm_pkg::REG_SLOT_HOLD:    slot_hold         <= pwdata[CW-1:0];
        owbm_pkg::REG_SLOT_REC:     slot_recovery     <= pwdata[CW-1:0];
        owbm_pkg::REG_SAMPLE_DELAY: read_sample_delay <= pwdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (owbm_pkg::reg_idx_t'(paddr[4:2]))
      owbm_pkg::REG_RESET_LOW:    prdata[CW-1:0] = reset_low_time;
      owbm_pkg::REG_PRES_WAIT:    prdata[CW-1:0] = presence_wait;
      owbm_pkg::REG_PRES_TAIL:    prdata[CW-1:0] = presence_tail;
      owbm_pkg::REG_SLOT_START:   prdata[CW-1:0] = slot_start;
      owbm_pkg::REG_SLOT_HOLD:    prdata[CW-1:0] = slot_hold;
      owbm_pkg::REG_SLOT_REC:     prdata[CW-1:0] = slot_recovery;
      owbm_pkg::REG_SAMPLE_DELAY: prdata[CW-1:0] = read_sample_delay;
      default:                    prdata = '0;
    endcase
  end

  // Sequencer: command start, tick countdown and phase advance
  assign time_dec = (time_left != '0) ? time_left - TIME_ONE : '0;

  always_comb begin
    phase_adv          = phase;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_seen_next = presence_seen;
    read_result_next   = read_result;
    enter_en           = 1'b0;
    enter_phase        = owbm_pkg::PH_IDLE;
    enter_reg          = owbm_pkg::REG_SLOT_REC;
    done               = 1'b0;
    rejected           = 1'b0;
    if (mode != owbm_pkg::MODE_TICK) begin
      if (phase != owbm_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        bit_index_next = '0;
        enter_en       = 1'b1;
        case (mode)
          owbm_pkg::MODE_RESET: begin
            enter_phase = owbm_pkg::PH_RST_PRE;
            enter_reg   = owbm_pkg::REG_SLOT_REC;
          end
          owbm_pkg::MODE_WRITE: begin
            shift_byte_next = data_byte;
            enter_phase     = owbm_pkg::PH_WR_START;
            enter_reg       = owbm_pkg::REG_SLOT_START;
          end
          default: begin
            enter_phase = owbm_pkg::PH_RD_START;
            enter_reg   = owbm_pkg::REG_SLOT_START;
          end
        endcase
      end
    end else if (phase != owbm_pkg::PH_IDLE && time_dec == '0) begin
      enter_en = 1'b1;
      case (phase)
        owbm_pkg::PH_RST_PRE: begin
          enter_phase = owbm_pkg::PH_RST_LOW;
          enter_reg   = owbm_pkg::REG_RESET_LOW;
        end
        owbm_pkg::PH_RST_LOW: begin
          enter_phase = owbm_pkg::PH_RST_WAIT;
          enter_reg   = owbm_pkg::REG_PRES_WAIT;
        end
        owbm_pkg::PH_RST_WAIT: begin
          presence_seen_next = bus_level;
          enter_phase        = owbm_pkg::PH_RST_TAIL;
          enter_reg          = owbm_pkg::REG_PRES_TAIL;
        end
        owbm_pkg::PH_RST_TAIL: begin
          enter_phase = owbm_pkg::PH_RST_POST;
          enter_reg   = owbm_pkg::REG_SLOT_REC;
        end
        owbm_pkg::PH_WR_START: begin
          enter_phase = owbm_pkg::PH_WR_BIT;
          enter_reg   = owbm_pkg::REG_SLOT_HOLD;
        end
        owbm_pkg::PH_WR_BIT: begin
          enter_phase = owbm_pkg::PH_WR_REC;
          enter_reg   = owbm_pkg::REG_SLOT_REC;
        end
        owbm_pkg::PH_WR_REC: begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
          bit_index_next  = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            enter_en  = 1'b0;
            phase_adv = owbm_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            enter_phase = owbm_pkg::PH_WR_START;
            enter_reg   = owbm_pkg::REG_SLOT_START;
          end
        end
        owbm_pkg::PH_RD_START: begin
          enter_phase = owbm_pkg::PH_RD_DELAY;
          enter_reg   = owbm_pkg::REG_SAMPLE_DELAY;
        end
        owbm_pkg::PH_RD_DELAY: begin
          shift_byte_next = {bus_level, shift_byte[7:1]};
          enter_phase     = owbm_pkg::PH_RD_HOLD;
          enter_reg       = owbm_pkg::REG_SLOT_HOLD;
        end
        owbm_pkg::PH_RD_HOLD: begin
          enter_phase = owbm_pkg::PH_RD_REC;
          enter_reg   = owbm_pkg::REG_SLOT_REC;
        end
        owbm_pkg::PH_RD_REC: begin
          bit_index_next = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            read_result_next = shift_byte;
            enter_en         = 1'b0;
            phase_adv        = owbm_pkg::PH_IDLE;
            done             = 1'b1;
          end else begin
            enter_phase = owbm_pkg::PH_RD_START;
            enter_reg   = owbm_pkg::REG_SLOT_START;
          end
        end
        default: begin
          // end of reset sequence, or an unknown phase: drop to idle
          enter_en  = 1'b0;
          phase_adv = owbm_pkg::PH_IDLE;
          done      = (phase == owbm_pkg::PH_RST_POST);
        end
      endcase
    end
  end

  always_comb begin
    case (enter_reg)
      owbm_pkg::REG_RESET_LOW:    cfg_sel = reset_low_time;
      owbm_pkg::REG_PRES_WAIT:    cfg_sel = presence_wait;
      owbm_pkg::REG_PRES_TAIL:    cfg_sel = presence_tail;
      owbm_pkg::REG_SLOT_START:   cfg_sel = slot_start;
      owbm_pkg::REG_SLOT_HOLD:    cfg_sel = slot_hold;
      owbm_pkg::REG_SLOT_REC:     cfg_sel = slot_recovery;
      owbm_pkg::REG_SAMPLE_DELAY: cfg_sel = read_sample_delay;
      default:                    cfg_sel = slot_recovery;
    endcase
    cfg_ext = EW'(cfg_sel);
    if (cfg_sel == '0) begin
      enter_time = TIME_ONE;
    end else if (cfg_ext > TIME_MAX) begin
      enter_time = TIME_MAX[TIME_WIDTH-1:0];
    end else begin
      enter_time = cfg_ext[TIME_WIDTH-1:0];
    end
  end

  always_comb begin
    if (enter_en) begin
      phase_next     = enter_phase;
      time_left_next = enter_time;
    end else if (mode == owbm_pkg::MODE_TICK && phase != owbm_pkg::PH_IDLE) begin
      phase_next     = phase_adv;
      time_left_next = (phase_adv == owbm_pkg::PH_IDLE) ? '0 : time_dec;
    end else begin
      phase_next     = phase;
      time_left_next = time_left;
    end
    case (phase_next)
      owbm_pkg::PH_RST_LOW,
      owbm_pkg::PH_WR_START,
      owbm_pkg::PH_RD_START: drive = 1'b1;
      owbm_pkg::PH_WR_BIT:   drive = ~shift_byte_next[0];
      default:               drive = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owbm_pkg::PH_IDLE;
      time_left     <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_seen <= 1'b1;
      read_result   <= '0;
    end else if (s_accept) begin
      phase         <= phase_next;
      time_left     <= time_left_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_seen <= presence_seen_next;
      read_result   <= read_result_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_axis_tdata <= {3'b000, rejected, read_result_next, presence_seen_next, done,
                       (phase_next != owbm_pkg::PH_IDLE), drive};
    end
  end

`ifndef SYNTHESIS
  a_busy_has_time: assert property (@(posedge clk) disable iff (rst)
    (phase != owbm_pkg::PH_IDLE) |-> (time_left != '0))
    else $error("running phase with empty tick count");

  a_idle_no_time: assert property (@(posedge clk) disable iff (rst)
    (phase == owbm_pkg::PH_IDLE) |-> (time_left == '0))
    else $error("idle phase with pending tick count");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (s_accept && mode != owbm_pkg::MODE_TICK && phase == owbm_pkg::PH_IDLE)
      |=> (phase != owbm_pkg::PH_IDLE && bit_index == '0))
    else $error("accepted command did not start a sequence");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (!m_axis_tdata[1] && !m_axis_tdata[12]))
    else $error("done word still busy or flagged rejected");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (s_accept && mode != owbm_pkg::MODE_TICK && phase != owbm_pkg::PH_IDLE)
      |=> ($stable(phase) && $stable(time_left) && $stable(shift_byte)))
    else $error("rejected command changed sequencer state");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking bench for one_wire_bus_master: directed words, then random
// command sequences over several APB timing settings, scored by fixed words or a line model.
// Depends on rtl/owbm_pkg.sv and rtl/one_wire_bus_master.sv.
module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [2:0] spare;
    logic       rejected;
    logic [7:0] rx_byte;
    logic       presence;
    logic       done;
    logic       busy;
    logic       drive_low;
  } line_word_t;

  typedef struct packed {
    logic            drain;
    owbm_pkg::mode_t m;
    logic            lvl;
    logic [7:0]      d;
    logic            typed;
    line_word_t      want;
  } plan_row_t;

  localparam line_word_t IDLE_AFTER_RST = '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam line_word_t SLOT_OPENED    = '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam line_word_t REFUSED_LOW    = '{3'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam line_word_t RESET_OPENED   = '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam line_word_t NO_WORD        = '0;

  localparam logic [owbm_pkg::CFG_WIDTH-1:0] TIMING_INIT [owbm_pkg::CFG_COUNT] = '{
    owbm_pkg::RESET_LOW_INIT, owbm_pkg::PRES_WAIT_INIT, owbm_pkg::PRES_TAIL_INIT,
    owbm_pkg::SLOT_START_INIT, owbm_pkg::SLOT_HOLD_INIT, owbm_pkg::SLOT_REC_INIT,
    owbm_pkg::SAMPLE_DELAY_INIT
  };

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [owbm_pkg::IN_TDATA_WIDTH-1:0] s_axis_tdata;
  logic [owbm_pkg::MODE_WIDTH-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [owbm_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [owbm_pkg::PADDR_WIDTH-1:0] paddr;
  logic [owbm_pkg::APB_DATA_WIDTH-1:0] pwdata;
  logic [owbm_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  one_wire_bus_master dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // line model state
  logic [owbm_pkg::CFG_WIDTH-1:0] timing [owbm_pkg::CFG_COUNT];
  owbm_pkg::phase_t line_phase;
  logic [9:0] slot_left;
  logic [2:0] bit_no;
  logic [7:0] shift_q;
  logic presence_q;
  logic [7:0] rx_byte_q;

  line_word_t bus_words_due [$];
  line_word_t got_word;
  line_word_t want_word;
  int gap_pct;
  int mismatches;
  int words_sent;
  int words_checked;
  int seq_done;
  int cmd_refused;
  int settings_used;
  int quiet_cycles;

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  function automatic void reset_line_model();
    for (int i = 0; i < owbm_pkg::CFG_COUNT; i++) timing[i] = TIMING_INIT[i];
    line_phase = owbm_pkg::PH_IDLE;
    slot_left = '0;
    bit_no = '0;
    shift_q = '0;
    presence_q = 1'b1;
    rx_byte_q = '0;
  endfunction

  function automatic void enter_stretch(input owbm_pkg::phase_t p,
                                        input owbm_pkg::reg_idx_t r);
    line_phase = p;
    slot_left = (timing[r] == '0) ? 10'd1 : timing[r];
  endfunction

  function automatic line_word_t predict_bus_word(input owbm_pkg::mode_t m, input logic lvl,
                                                  input logic [7:0] d);
    line_word_t w;
    logic fin;
    logic refused;
    fin = 1'b0;
    refused = 1'b0;
    if (m != owbm_pkg::MODE_TICK) begin
      if (line_phase != owbm_pkg::PH_IDLE) begin
        refused = 1'b1;
      end else begin
        bit_no = '0;
        case (m)
          owbm_pkg::MODE_RESET: enter_stretch(owbm_pkg::PH_RST_PRE, owbm_pkg::REG_SLOT_REC);
          owbm_pkg::MODE_WRITE: begin
            shift_q = d;
            enter_stretch(owbm_pkg::PH_WR_START, owbm_pkg::REG_SLOT_START);
          end
          default: enter_stretch(owbm_pkg::PH_RD_START, owbm_pkg::REG_SLOT_START);
        endcase
      end
    end else if (line_phase != owbm_pkg::PH_IDLE) begin
      if (slot_left != '0) slot_left = slot_left - 10'd1;
      if (slot_left == '0) begin
        case (line_phase)
          owbm_pkg::PH_RST_PRE:
            enter_stretch(owbm_pkg::PH_RST_LOW, owbm_pkg::REG_RESET_LOW);
          owbm_pkg::PH_RST_LOW:
            enter_stretch(owbm_pkg::PH_RST_WAIT, owbm_pkg::REG_PRES_WAIT);
          owbm_pkg::PH_RST_WAIT: begin
            presence_q = lvl;
            enter_stretch(owbm_pkg::PH_RST_TAIL, owbm_pkg::REG_PRES_TAIL);
          end
          owbm_pkg::PH_RST_TAIL:
            enter_stretch(owbm_pkg::PH_RST_POST, owbm_pkg::REG_SLOT_REC);
          owbm_pkg::PH_WR_START:
            enter_stretch(owbm_pkg::PH_WR_BIT, owbm_pkg::REG_SLOT_HOLD);
          owbm_pkg::PH_WR_BIT:
            enter_stretch(owbm_pkg::PH_WR_REC, owbm_pkg::REG_SLOT_REC);
          owbm_pkg::PH_WR_REC: begin
            shift_q = shift_q >> 1;
            bit_no = bit_no + 3'd1;
            if (bit_no == '0) begin
              line_phase = owbm_pkg::PH_IDLE;
              slot_left = '0;
              fin = 1'b1;
            end else begin
              enter_stretch(owbm_pkg::PH_WR_START, owbm_pkg::REG_SLOT_START);
            end
          end
          owbm_pkg::PH_RD_START:
            enter_stretch(owbm_pkg::PH_RD_DELAY, owbm_pkg::REG_SAMPLE_DELAY);
          owbm_pkg::PH_RD_DELAY: begin
            shift_q = {lvl, shift_q[7:1]};
            enter_stretch(owbm_pkg::PH_RD_HOLD, owbm_pkg::REG_SLOT_HOLD);
          end
          owbm_pkg::PH_RD_HOLD:
            enter_stretch(owbm_pkg::PH_RD_REC, owbm_pkg::REG_SLOT_REC);
          owbm_pkg::PH_RD_REC: begin
            bit_no = bit_no + 3'd1;
            if (bit_no == '0) begin
              rx_byte_q = shift_q;
              line_phase = owbm_pkg::PH_IDLE;
              slot_left = '0;
              fin = 1'b1;
            end else begin
              enter_stretch(owbm_pkg::PH_RD_START, owbm_pkg::REG_SLOT_START);
            end
          end
          default: begin
            fin = (line_phase == owbm_pkg::PH_RST_POST);
            line_phase = owbm_pkg::PH_IDLE;
            slot_left = '0;
          end
        endcase
      end
    end
    w = '0;
    if (line_phase == owbm_pkg::PH_RST_LOW || line_phase == owbm_pkg::PH_WR_START ||
        line_phase == owbm_pkg::PH_RD_START)
      w.drive_low = 1'b1;
    else if (line_phase == owbm_pkg::PH_WR_BIT)
      w.drive_low = ~shift_q[0];
    w.busy = (line_phase != owbm_pkg::PH_IDLE);
    w.done = fin;
    w.presence = presence_q;
    w.rx_byte = rx_byte_q;
    w.rejected = refused;
    return w;
  endfunction

  // source: every call starts and ends at a falling edge
  task automatic send_word(input owbm_pkg::mode_t m, input logic lvl, input logic [7:0] d,
                           input logic typed, input line_word_t want);
    line_word_t w;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {7'd0, d, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    w = predict_bus_word(m, lvl, d);
    if (w.done) seq_done++;
    if (w.rejected) cmd_refused++;
    bus_words_due.push_back(typed ? want : w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic finish_sequence(input logic rand_lvl, input logic lvl);
    while (line_phase != owbm_pkg::PH_IDLE)
      send_word(owbm_pkg::MODE_TICK, rand_lvl ? 1'($urandom_range(0, 1)) : lvl,
                8'($urandom_range(0, 255)), 1'b0, NO_WORD);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input owbm_pkg::reg_idx_t r,
                            input logic [9:0] v,
                            output logic [owbm_pkg::APB_DATA_WIDTH-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= {22'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_timing(input owbm_pkg::reg_idx_t r);
    logic [owbm_pkg::APB_DATA_WIDTH-1:0] rd;
    apb_access(1'b0, r, 10'd0, rd);
    if (rd !== {22'd0, timing[r]})
      flag($sformatf("reg %s read %h, want %h", r.name(), rd, timing[r]));
  endtask

  task automatic program_timing(input owbm_pkg::reg_idx_t r, input logic [9:0] v);
    logic [owbm_pkg::APB_DATA_WIDTH-1:0] rd;
    apb_access(1'b1, r, v, rd);
    timing[r] = v;
    check_timing(r);
  endtask

  task automatic apply_timings(input int lo, input int hi);
    wait_results();
    for (int i = 0; i < owbm_pkg::CFG_COUNT; i++)
      program_timing(owbm_pkg::reg_idx_t'(i), 10'($urandom_range(lo, hi)));
    settings_used++;
  endtask

  // well-formed sequences with random content, plus some stray words
  task automatic run_traffic(input int target);
    int n;
    owbm_pkg::mode_t m;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 99) < 75) begin
        send_word(owbm_pkg::mode_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        n++;
        while (line_phase != owbm_pkg::PH_IDLE) begin
          m = ($urandom_range(0, 99) < 4) ? owbm_pkg::mode_t'($urandom_range(1, 3)) :
                                            owbm_pkg::MODE_TICK;
          send_word(m, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
          n++;
        end
      end else begin
        m = owbm_pkg::mode_t'($urandom_range(0, 3));
        send_word(m, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        n++;
      end
    end
    finish_sequence(1'b1, 1'b0);
  endtask

  // sink with random stall bursts
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_word = m_axis_tdata;
      if (bus_words_due.size() == 0) begin
        flag($sformatf("unexpected word %h", got_word));
      end else begin
        want_word = bus_words_due.pop_front();
        words_checked++;
        if (got_word.drive_low !== want_word.drive_low || got_word.busy !== want_word.busy ||
            got_word.done !== want_word.done || got_word.presence !== want_word.presence ||
            got_word.rx_byte !== want_word.rx_byte ||
            got_word.rejected !== want_word.rejected || got_word.spare !== want_word.spare)
          flag($sformatf({"word %0d: want drv=%b busy=%b done=%b pres=%b byte=%h rej=%b",
                          " got drv=%b busy=%b done=%b pres=%b byte=%h rej=%b spare=%b"},
                         words_checked, want_word.drive_low, want_word.busy, want_word.done,
                         want_word.presence, want_word.rx_byte, want_word.rejected,
                         got_word.drive_low, got_word.busy, got_word.done,
                         got_word.presence, got_word.rx_byte, got_word.rejected,
                         got_word.spare));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d words pending",
               quiet_cycles, bus_words_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan [25];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = owbm_pkg::MODE_TICK;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pct = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    seq_done = 0;
    cmd_refused = 0;
    settings_used = 0;
    reset_line_model();
    plan = '{
      '{1'b0, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b1, IDLE_AFTER_RST},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'hFF, 1'b1, IDLE_AFTER_RST},
      '{1'b0, owbm_pkg::MODE_WRITE, 1'b0, 8'h00, 1'b1, SLOT_OPENED},
      '{1'b0, owbm_pkg::MODE_RESET, 1'b1, 8'hFF, 1'b1, REFUSED_LOW},
      '{1'b0, owbm_pkg::MODE_READ,  1'b0, 8'h55, 1'b1, REFUSED_LOW},
      '{1'b0, owbm_pkg::MODE_WRITE, 1'b1, 8'hAA, 1'b1, REFUSED_LOW},
      '{1'b1, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_WRITE, 1'b0, 8'hFF, 1'b1, SLOT_OPENED},
      '{1'b1, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_RESET, 1'b0, 8'h00, 1'b1, RESET_OPENED},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'hFF, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_RESET, 1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b1, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_READ,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b1, owbm_pkg::MODE_TICK,  1'b1, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_READ,  1'b1, 8'hFF, 1'b0, NO_WORD},
      '{1'b1, owbm_pkg::MODE_TICK,  1'b0, 8'h00, 1'b0, NO_WORD},
      '{1'b0, owbm_pkg::MODE_TICK,  1'b1, 8'hFF, 1'b0, NO_WORD}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < owbm_pkg::CFG_COUNT; i++) check_timing(owbm_pkg::reg_idx_t'(i));

    // zero timings count as one tick
    apply_timings(0, 0);
    gap_pct = 5;
    foreach (plan[i]) begin
      if (plan[i].drain) finish_sequence(1'b0, plan[i].lvl);
      else send_word(plan[i].m, plan[i].lvl, plan[i].d, plan[i].typed, plan[i].want);
    end

    apply_timings(1, 3);
    run_traffic(120);

    gap_pct = 0;
    apply_timings(0, 6);
    run_traffic(120);

    // longer stretches: one full reset sequence
    gap_pct = 3;
    apply_timings(30, 40);
    send_word(owbm_pkg::MODE_RESET, 1'b0, 8'h00, 1'b0, NO_WORD);
    finish_sequence(1'b1, 1'b0);

    gap_pct = 10;
    apply_timings(1, 8);
    run_traffic(150);

    gap_pct = 0;
    apply_timings(1, 3);
    run_traffic(120);

    wait_results();
    repeat (8) @(negedge clk);

    $display("Sent %0d words under %0d timing settings, scored %0d result words",
             words_sent, settings_used, words_checked);
    $display("Sequences completed: %0d, commands refused while busy: %0d, mismatches: %0d",
             seq_done, cmd_refused, mismatches);
    if (mismatches == 0 && bus_words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
